// ===== src/akpc_pkg.sv =====
`default_nettype none

package akpc_pkg;

  localparam int FRAC_BITS              = 10;
  localparam int RATE_TO_ANGLE_SHIFT    = 10;
  localparam int ANGLE_CORRECTION_SHIFT = 8;
  localparam int BIAS_CORRECTION_SHIFT  = 16;

  localparam int ACC_W  = 40;
  localparam int SMP_W  = 16;
  localparam int FX_W   = SMP_W + FRAC_BITS;
  localparam int EST_W  = 32;
  localparam int OUT_W  = 16;
  localparam int GAIN_W = 16;
  localparam int SP_W   = 8;
  localparam int DRV_W  = 9;
  localparam int EPS_W  = 14;
  localparam int PROD_W = GAIN_W + 1 + EPS_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int SP_LEVEL    = 90;
  localparam int DRV_NEUTRAL = 180;
  localparam int DRV_MAX     = 360;
  localparam int SP_SHIFT    = 2;
  localparam int ANGLE_SHIFT = 4;
  localparam int RATE_SHIFT  = 2;
  localparam int DRV_SHIFT   = 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [EST_W-1:0]  est_val_t;
  typedef logic signed [OUT_W-1:0]  out_val_t;
  typedef logic signed [EPS_W-1:0]  eps_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_ANGLE_GAIN = 1'b0,
    REG_RATE_GAIN  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            axis;
    logic [SP_W-1:0] setpoint;
    fx_t             ang_fx;
    fx_t             rate_fx;
  } item_t;

  typedef struct packed {
    logic            axis;
    logic [SP_W-1:0] setpoint;
    out_val_t        frate;
    out_val_t        fang;
  } est_t;

  typedef struct packed {
    logic [GAIN_W-1:0] angle_gain;
    logic [GAIN_W-1:0] rate_gain;
  } gains_t;

  localparam est_val_t EST_HI = {1'b0, {(EST_W-1){1'b1}}};
  localparam est_val_t EST_LO = {1'b1, {(EST_W-1){1'b0}}};
  localparam out_val_t OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_val_t OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic est_val_t sat_est(input acc_t x);
    if (x > acc_t'(EST_HI)) begin
      sat_est = EST_HI;
    end else if (x < acc_t'(EST_LO)) begin
      sat_est = EST_LO;
    end else begin
      sat_est = x[EST_W-1:0];
    end
  endfunction

  function automatic out_val_t sat_out(input acc_t x);
    if (x > acc_t'(OUT_HI)) begin
      sat_out = OUT_HI;
    end else if (x < acc_t'(OUT_LO)) begin
      sat_out = OUT_LO;
    end else begin
      sat_out = x[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/akpc_regs.sv =====
`default_nettype none

module akpc_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [akpc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [akpc_pkg::DATA_W-1:0]  pwdata,
  output logic      [akpc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output akpc_pkg::gains_t                  gains_o
);

  akpc_pkg::gains_t   gains_q;
  akpc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = akpc_pkg::reg_idx_e'(paddr[akpc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign gains_o = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (wr_en) begin
      case (idx)
        akpc_pkg::REG_ANGLE_GAIN: gains_q.angle_gain <= pwdata[akpc_pkg::GAIN_W-1:0];
        akpc_pkg::REG_RATE_GAIN:  gains_q.rate_gain  <= pwdata[akpc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      akpc_pkg::REG_ANGLE_GAIN:
        prdata = {{(akpc_pkg::DATA_W-akpc_pkg::GAIN_W){1'b0}}, gains_q.angle_gain};
      akpc_pkg::REG_RATE_GAIN:
        prdata = {{(akpc_pkg::DATA_W-akpc_pkg::GAIN_W){1'b0}}, gains_q.rate_gain};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/akpc_front.sv =====
`default_nettype none

module akpc_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              axis_i,
  input  wire logic        [akpc_pkg::SP_W-1:0]  setpoint_i,
  input  wire logic signed [akpc_pkg::SMP_W-1:0] angle_sample_i,
  input  wire logic signed [akpc_pkg::SMP_W-1:0] rate_sample_i,
  output akpc_pkg::item_t                        item_o,
  output logic                                   item_valid_o,
  input  wire logic                              item_pop_i
);

  akpc_pkg::item_t                    fifo_q [akpc_pkg::QDEPTH];
  logic [akpc_pkg::QPTR_W-1:0]        wr_ptr_q;
  logic [akpc_pkg::QPTR_W-1:0]        rd_ptr_q;
  logic [akpc_pkg::QCNT_W-1:0]        cnt_q;
  akpc_pkg::item_t                    in_item;
  logic                               push;
  logic                               pop;

  assign in_item.axis     = axis_i;
  assign in_item.setpoint = setpoint_i;
  assign in_item.ang_fx   = akpc_pkg::fx_t'(angle_sample_i) <<< akpc_pkg::FRAC_BITS;
  assign in_item.rate_fx  = akpc_pkg::fx_t'(rate_sample_i) <<< akpc_pkg::FRAC_BITS;

  assign in_ready_o   = (cnt_q != akpc_pkg::QCNT_W'(akpc_pkg::QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/akpc_estimator.sv =====
`default_nettype none

module akpc_estimator (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire akpc_pkg::item_t item_i,
  input  wire logic      item_valid_i,
  output logic           item_pop_o,
  output akpc_pkg::est_t est_o,
  output logic           est_valid_o,
  input  wire logic      est_ready_i
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INTEG,
    ST_ERR,
    ST_UPD
  } state_e;

  state_e                      state_q;
  akpc_pkg::est_val_t          bias_q  [2];
  akpc_pkg::est_val_t          angle_q [2];

  logic                        ax_q;
  logic [akpc_pkg::SP_W-1:0]   sp_q;
  akpc_pkg::fx_t               ang_fx_q;
  akpc_pkg::est_val_t          bias_cur_q;
  akpc_pkg::acc_t              rk_q;
  akpc_pkg::acc_t              est_q;
  akpc_pkg::acc_t              err_q;
  akpc_pkg::out_val_t          frate_q;

  akpc_pkg::acc_t              rk_d;
  akpc_pkg::acc_t              est_d;
  akpc_pkg::acc_t              err_d;
  akpc_pkg::out_val_t          frate_d;
  akpc_pkg::acc_t              est_new;
  akpc_pkg::acc_t              bias_new;
  logic                        hand_off;

  assign item_pop_o = (state_q == ST_LOAD) && item_valid_i;

  assign rk_d    = akpc_pkg::acc_t'(item_i.rate_fx) - akpc_pkg::acc_t'(bias_q[item_i.axis]);
  assign est_d   = akpc_pkg::acc_t'(angle_q[ax_q]) + (rk_q >>> akpc_pkg::RATE_TO_ANGLE_SHIFT);
  assign frate_d = akpc_pkg::sat_out(rk_q >>> akpc_pkg::FRAC_BITS);
  assign err_d   = est_q - akpc_pkg::acc_t'(ang_fx_q);

  assign est_new  = est_q - (err_q >>> akpc_pkg::ANGLE_CORRECTION_SHIFT);
  assign bias_new = akpc_pkg::acc_t'(bias_cur_q) + (err_q >>> akpc_pkg::BIAS_CORRECTION_SHIFT);

  assign est_valid_o    = (state_q == ST_UPD);
  assign hand_off       = est_valid_o && est_ready_i;
  assign est_o.axis     = ax_q;
  assign est_o.setpoint = sp_q;
  assign est_o.frate    = frate_q;
  assign est_o.fang     = akpc_pkg::sat_out(est_new >>> akpc_pkg::FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      bias_q[0]  <= '0;
      bias_q[1]  <= '0;
      angle_q[0] <= '0;
      angle_q[1] <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (item_pop_o) begin
            state_q <= ST_INTEG;
          end
        end
        ST_INTEG: state_q <= ST_ERR;
        ST_ERR:   state_q <= ST_UPD;
        ST_UPD: begin
          if (hand_off) begin
            angle_q[ax_q] <= akpc_pkg::sat_est(est_new);
            bias_q[ax_q]  <= akpc_pkg::sat_est(bias_new);
            state_q       <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      ax_q       <= item_i.axis;
      sp_q       <= item_i.setpoint;
      ang_fx_q   <= item_i.ang_fx;
      bias_cur_q <= bias_q[item_i.axis];
      rk_q       <= rk_d;
    end
    if (state_q == ST_INTEG) begin
      est_q   <= est_d;
      frate_q <= frate_d;
    end
    if (state_q == ST_ERR) begin
      err_q <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/akpc_drive.sv =====
`default_nettype none

module akpc_drive (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire akpc_pkg::gains_t              gains_i,
  input  wire akpc_pkg::est_t                est_i,
  input  wire logic                          est_valid_i,
  output logic                               est_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               axis_out_o,
  output logic        [akpc_pkg::DRV_W-1:0]  drive_o,
  output logic signed [akpc_pkg::OUT_W-1:0]  filtered_rate_o,
  output logic signed [akpc_pkg::OUT_W-1:0]  filtered_angle_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic                   ax1_q, ax2_q;
  akpc_pkg::out_val_t     frate1_q, frate2_q, fang1_q, fang2_q;
  akpc_pkg::eps_t         eps1_q;
  akpc_pkg::prod_t        p2_1_q, p2_2_q, p1_2_q;

  akpc_pkg::eps_t         sp_term;
  akpc_pkg::eps_t         ang_term;
  akpc_pkg::eps_t         eps_d;
  akpc_pkg::eps_t         rate_term;
  akpc_pkg::prod_t        p2_d;
  akpc_pkg::prod_t        p1_d;
  akpc_pkg::sum_t         v_sum;
  akpc_pkg::sum_t         drv_raw;
  logic [akpc_pkg::DRV_W-1:0] drv_d;

  assign rdy3        = !v3_q || out_ready_i;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign est_ready_o = rdy1;
  assign out_valid_o = v3_q;

  assign sp_term  = (akpc_pkg::eps_t'($signed({1'b0, est_i.setpoint}))
                     - akpc_pkg::eps_t'(akpc_pkg::SP_LEVEL)) <<< akpc_pkg::SP_SHIFT;
  assign ang_term = akpc_pkg::eps_t'(est_i.fang >>> akpc_pkg::ANGLE_SHIFT);
  assign eps_d    = est_i.axis ? (sp_term - ang_term) : (sp_term + ang_term);

  assign rate_term = akpc_pkg::eps_t'(est_i.frate >>> akpc_pkg::RATE_SHIFT);
  assign p2_d      = akpc_pkg::prod_t'($signed({1'b0, gains_i.rate_gain}))
                     * akpc_pkg::prod_t'(rate_term);
  assign p1_d      = akpc_pkg::prod_t'($signed({1'b0, gains_i.angle_gain}))
                     * akpc_pkg::prod_t'(eps1_q);

  assign v_sum   = akpc_pkg::sum_t'(p1_2_q) + akpc_pkg::sum_t'(p2_2_q);
  assign drv_raw = (v_sum >>> akpc_pkg::DRV_SHIFT) + akpc_pkg::sum_t'(akpc_pkg::DRV_NEUTRAL);

  always_comb begin
    if (drv_raw < akpc_pkg::sum_t'(0)) begin
      drv_d = '0;
    end else if (drv_raw > akpc_pkg::sum_t'(akpc_pkg::DRV_MAX)) begin
      drv_d = akpc_pkg::DRV_W'(akpc_pkg::DRV_MAX);
    end else begin
      drv_d = drv_raw[akpc_pkg::DRV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= est_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && est_valid_i) begin
      ax1_q    <= est_i.axis;
      frate1_q <= est_i.frate;
      fang1_q  <= est_i.fang;
      eps1_q   <= eps_d;
      p2_1_q   <= p2_d;
    end
    if (rdy2 && v1_q) begin
      ax2_q    <= ax1_q;
      frate2_q <= frate1_q;
      fang2_q  <= fang1_q;
      p1_2_q   <= p1_d;
      p2_2_q   <= p2_1_q;
    end
    if (rdy3 && v2_q) begin
      axis_out_o       <= ax2_q;
      drive_o          <= drv_d;
      filtered_rate_o  <= frate2_q;
      filtered_angle_o <= fang2_q;
    end
  end

endmodule

`default_nettype wire

// ===== src/attitude_kalman_p_controller_top.sv =====
// Two-axis attitude estimator with cascaded proportional drive.
// Input channel (in_valid_i/in_ready_o): one transaction carries an axis,
// a setpoint and raw angle and rate samples. Output channel
// (out_valid_o/out_ready_i): one transaction per input with the axis, the
// clamped drive and the filtered rate and angle.
// Gains are written over the APB port (angle_gain at 0x0, rate_gain at 0x4);
// the user must write them only while the block is idle; it does not enforce this.
// A two-entry input queue feeds the estimator sequencer, which steps through
// load, integrate, error and update for each transaction and takes no new one
// until the update is handed off, because each transaction reads the per-axis
// bias and angle left by the previous one.
// A three-stage drive pipeline with its own output register follows, so the
// estimator keeps working while a result waits; when out_ready_i stays low
// the pipeline and the queue fill and in_ready_o drops.
// Reset clears gains, per-axis bias and angle estimates and all valids.
`default_nettype none

module attitude_kalman_p_controller_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [akpc_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [akpc_pkg::DATA_W-1:0]       pwdata,
  output logic      [akpc_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              axis_i,
  input  wire logic        [akpc_pkg::SP_W-1:0]  setpoint_i,
  input  wire logic signed [akpc_pkg::SMP_W-1:0] angle_sample_i,
  input  wire logic signed [akpc_pkg::SMP_W-1:0] rate_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   axis_out_o,
  output logic        [akpc_pkg::DRV_W-1:0]      drive_o,
  output logic signed [akpc_pkg::OUT_W-1:0]      filtered_rate_o,
  output logic signed [akpc_pkg::OUT_W-1:0]      filtered_angle_o
);

  akpc_pkg::gains_t gains;
  akpc_pkg::item_t  item;
  logic             item_valid;
  logic             item_pop;
  akpc_pkg::est_t   est;
  logic             est_valid;
  logic             est_ready;

  akpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  akpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .axis_i         (axis_i),
    .setpoint_i     (setpoint_i),
    .angle_sample_i (angle_sample_i),
    .rate_sample_i  (rate_sample_i),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  akpc_estimator u_estimator (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .est_o        (est),
    .est_valid_o  (est_valid),
    .est_ready_i  (est_ready)
  );

  akpc_drive u_drive (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .gains_i          (gains),
    .est_i            (est),
    .est_valid_i      (est_valid),
    .est_ready_o      (est_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .axis_out_o       (axis_out_o),
    .drive_o          (drive_o),
    .filtered_rate_o  (filtered_rate_o),
    .filtered_angle_o (filtered_angle_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/attitude_kalman_p_controller_top_test.sv =====
`timescale 1ns / 100ps

module attitude_kalman_p_controller_top_test;
  import akpc_pkg::*;

  localparam int CLK_HIGH      = 6;
  localparam int CLK_LOW       = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;

  localparam logic AXIS_ROLL  = 1'b0;
  localparam logic AXIS_PITCH = 1'b1;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef struct packed {
    logic             axis;
    logic [DRV_W-1:0] drive;
    out_val_t         frate;
    out_val_t         fang;
  } attitude_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    axis_i = 1'b0;
  logic [SP_W-1:0]         setpoint_i = '0;
  logic signed [SMP_W-1:0] angle_sample_i = '0;
  logic signed [SMP_W-1:0] rate_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    axis_out_o;
  logic [DRV_W-1:0]        drive_o;
  logic signed [OUT_W-1:0] filtered_rate_o;
  logic signed [OUT_W-1:0] filtered_angle_o;

  attitude_result_t expected_attitude[$];
  longint           kept_bias [2] = '{0, 0};
  longint           kept_angle[2] = '{0, 0};
  logic [GAIN_W-1:0] angle_gain_q = '0;
  logic [GAIN_W-1:0] rate_gain_q = '0;
  int               walk_angle[2] = '{0, 0};

  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  attitude_kalman_p_controller_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .axis_i           (axis_i),
    .setpoint_i       (setpoint_i),
    .angle_sample_i   (angle_sample_i),
    .rate_sample_i    (rate_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .axis_out_o       (axis_out_o),
    .drive_o          (drive_o),
    .filtered_rate_o  (filtered_rate_o),
    .filtered_angle_o (filtered_angle_o)
  );

  always begin
    #CLK_LOW clk_i = 1'b1;
    #CLK_HIGH clk_i = 1'b0;
  end

  function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  function automatic attitude_result_t predict_attitude(input logic ax,
                                                        input logic [SP_W-1:0] sp,
                                                        input logic signed [SMP_W-1:0] ang,
                                                        input logic signed [SMP_W-1:0] rate);
    longint ang_fx, rate_fx, rk, est, err, bias, frate, fang, eps, v;
    attitude_result_t r;
    ang_fx  = longint'(ang) <<< FRAC_BITS;
    rate_fx = longint'(rate) <<< FRAC_BITS;
    rk   = rate_fx - kept_bias[ax];
    est  = kept_angle[ax] + (rk >>> RATE_TO_ANGLE_SHIFT);
    err  = est - ang_fx;
    est  = est - (err >>> ANGLE_CORRECTION_SHIFT);
    bias = kept_bias[ax] + (err >>> BIAS_CORRECTION_SHIFT);
    kept_angle[ax] = clamp_range(est, longint'(EST_LO), longint'(EST_HI));
    kept_bias[ax]  = clamp_range(bias, longint'(EST_LO), longint'(EST_HI));
    frate = clamp_range(rk >>> FRAC_BITS, longint'(OUT_LO), longint'(OUT_HI));
    fang  = clamp_range(est >>> FRAC_BITS, longint'(OUT_LO), longint'(OUT_HI));
    eps = (longint'(sp) - SP_LEVEL) <<< SP_SHIFT;
    if (ax == AXIS_ROLL) begin
      eps = eps + (fang >>> ANGLE_SHIFT);
    end else begin
      eps = eps - (fang >>> ANGLE_SHIFT);
    end
    v = longint'(angle_gain_q) * eps + longint'(rate_gain_q) * (frate >>> RATE_SHIFT);
    r.axis  = ax;
    r.drive = DRV_W'(clamp_range((v >>> DRV_SHIFT) + DRV_NEUTRAL, 0, DRV_MAX));
    r.frate = OUT_W'(frate);
    r.fang  = OUT_W'(fang);
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] sample_edge();
    case ($urandom_range(3))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  always @(posedge clk_i) begin : check_results
    attitude_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_attitude.size() == 0) begin
        $error("unexpected result transaction on axis %0d", axis_out_o);
        mismatch_count++;
      end else begin
        want = expected_attitude.pop_front();
        if (axis_out_o !== want.axis) begin
          $error("axis_out: expected %0d, actual %0d", want.axis, axis_out_o);
          mismatch_count++;
        end
        if (drive_o !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, drive_o);
          mismatch_count++;
        end
        if (filtered_rate_o !== want.frate) begin
          $error("filtered_rate: expected %0d, actual %0d", want.frate, filtered_rate_o);
          mismatch_count++;
        end
        if (filtered_angle_o !== want.fang) begin
          $error("filtered_angle: expected %0d, actual %0d", want.fang, filtered_angle_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_idling(input int send_pct, input int stall_v);
    sender_idle_pct = send_pct;
    stall_pct <= stall_v;
  endtask

  task automatic send_sample(input logic ax, input logic [SP_W-1:0] sp,
                             input logic signed [SMP_W-1:0] ang,
                             input logic signed [SMP_W-1:0] rate);
    attitude_result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    axis_i         <= ax;
    setpoint_i     <= sp;
    angle_sample_i <= ang;
    rate_sample_i  <= rate;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_attitude(ax, sp, ang, rate);
    expected_attitude.push_back(want);
  endtask

  task automatic send_random_sample();
    int pick;
    logic ax;
    logic [SP_W-1:0] sp;
    pick = $urandom_range(99);
    ax = 1'($urandom_range(1));
    if (pick < 60) begin
      if ($urandom_range(49) == 0) begin
        walk_angle[ax] = int'($urandom_range(8000)) - 4000;
      end else begin
        walk_angle[ax] = walk_angle[ax] + int'($urandom_range(40)) - 20;
      end
      send_sample(ax, SP_W'($urandom_range(180)),
                  SMP_W'(walk_angle[ax] + int'($urandom_range(64)) - 32),
                  SMP_W'(int'($urandom_range(600)) - 300));
    end else if (pick < 85) begin
      send_sample(ax, SP_W'($urandom_range(255)), SMP_W'($urandom), SMP_W'($urandom));
    end else begin
      case ($urandom_range(4))
        0: sp = 8'd0;
        1: sp = 8'd90;
        2: sp = 8'd180;
        3: sp = 8'd181;
        default: sp = 8'd255;
      endcase
      send_sample(ax, sp, sample_edge(), sample_edge());
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_attitude.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_gain(input reg_idx_e idx, input logic [GAIN_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'b0, val}) begin
      $error("%s readback: expected %0d, actual %0d", idx.name(), val, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_gain(input reg_idx_e idx, input logic [GAIN_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ANGLE_GAIN) begin
      angle_gain_q = val;
    end else begin
      rate_gain_q = val;
    end
    check_gain(idx, val);
  endtask

  task automatic test_reset_state();
    check_gain(REG_ANGLE_GAIN, '0);
    check_gain(REG_RATE_GAIN, '0);
    send_sample(AXIS_ROLL, 8'd0, SMP_MAX, SMP_MIN);
    send_sample(AXIS_PITCH, 8'd255, SMP_MIN, SMP_MAX);
  endtask

  task automatic test_directed_extremes();
    wait_idle();
    write_gain(REG_ANGLE_GAIN, 16'hFFFF);
    write_gain(REG_RATE_GAIN, 16'hFFFF);
    send_sample(AXIS_ROLL, 8'd0, '0, '0);
    send_sample(AXIS_PITCH, 8'd180, '0, '0);
    send_sample(AXIS_ROLL, 8'd181, '0, '0);
    send_sample(AXIS_PITCH, 8'd255, '0, '0);
    send_sample(AXIS_ROLL, 8'd90, '0, '0);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[2], 8'd90, i[1] ? SMP_MAX : SMP_MIN, i[0] ? SMP_MAX : SMP_MIN);
    end
  endtask

  // Hold one axis at full scale long enough for the estimate to run past
  // the output range, with random samples on either axis interleaved now and then.
  task automatic test_estimate_windup();
    wait_idle();
    write_gain(REG_ANGLE_GAIN, 16'hFFFF);
    write_gain(REG_RATE_GAIN, 16'h0000);
    set_idling(26, 26);
    repeat (450) begin
      if ($urandom_range(7) == 0) begin
        send_random_sample();
      end else begin
        send_sample(AXIS_PITCH, SP_W'($urandom_range(180)),
                    SMP_W'(int'(SMP_MAX) - int'($urandom_range(15))),
                    SMP_W'(int'(SMP_MAX) - int'($urandom_range(15))));
      end
    end
    wait_idle();
    write_gain(REG_ANGLE_GAIN, 16'h0000);
    write_gain(REG_RATE_GAIN, 16'hFFFF);
    repeat (450) begin
      if ($urandom_range(7) == 0) begin
        send_random_sample();
      end else begin
        send_sample(AXIS_ROLL, SP_W'($urandom_range(180)),
                    SMP_W'(int'(SMP_MIN) + int'($urandom_range(15))),
                    SMP_W'(int'(SMP_MIN) + int'($urandom_range(15))));
      end
    end
  endtask

  task automatic run_flight_phase(input int send_pct, input int stall_v);
    for (int g = 0; g < 2; g++) begin
      wait_idle();
      write_gain(REG_ANGLE_GAIN, g ? GAIN_W'($urandom_range(1023)) : GAIN_W'($urandom));
      write_gain(REG_RATE_GAIN, g ? GAIN_W'($urandom_range(1023)) : GAIN_W'($urandom));
      set_idling(send_pct, stall_v);
      repeat (100) send_random_sample();
    end
  endtask

  task automatic test_random_flight();
    run_flight_phase(0, 0);
    run_flight_phase(62, 0);
    run_flight_phase(0, 62);
    run_flight_phase(26, 26);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_idling(0, 0);
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_random_sample();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_extremes();
    test_estimate_windup();
    test_random_flight();
    test_output_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
